@@ src/cjklb_pkg.sv @@
// Package for the CJK line-break classifier: result types, taboo tables and decision functions.
`timescale 1ns / 1ps

package cjklb_pkg;

    // Default width of the saturating byte position counter.
    localparam int POSITION_BITS_DEFAULT = 16;

    // Depth of the result queue; it must be a power of two of at least four.
    localparam int QUEUE_DEPTH = 4;

    // Width of the char_start field.
    localparam int START_BITS = 16;

    // One result transaction.
    typedef struct packed {
        logic [START_BITS-1:0] char_start;
        logic [2:0]            char_bytes;
        logic                  break_allowed;
        logic                  cut_off;
        logic                  end_of_text;
    } result_t;

    // Results produced by one text byte: the held-back character first, then the current one.
    typedef struct packed {
        logic    a_valid;
        result_t a;
        logic    b_valid;
        result_t b;
    } push_t;

    // Properties of one assembled character that its break decision needs.
    typedef struct packed {
        logic len1;
        logic ascii_brk;
        logic end_taboo;
        logic cjk_range;
    } char_flags_t;

    // Lead byte length code packed two bits per high nibble.
    localparam logic [31:0] LEAD_LENGTH_CODES = 32'hE500_0000;

    // Characters that may not start a line.
    localparam int BEGIN_COUNT = 62;
    localparam logic [31:0] BEGIN_LIST [BEGIN_COUNT] = '{
        32'hE3808100, 32'hE3808200, 32'hEFBC8C00, 32'hEFBC8E00, 32'hEFBC9A00, 32'hEFBC9B00,
        32'hEFBC9F00, 32'hEFBC8100, 32'hE2809900, 32'hE2809D00, 32'hEFBC8900, 32'hE3809500,
        32'hEFBCBD00, 32'hEFBD9D00, 32'hE3808900, 32'hE3808B00, 32'hE3808D00, 32'hE3808F00,
        32'hE3809100, 32'hE3808500, 32'hE383BC00, 32'hE3818100, 32'hE3818300, 32'hE3818500,
        32'hE3818700, 32'hE3818900, 32'hE381A300, 32'hE3828300, 32'hE3828500, 32'hE3828700,
        32'hE3828E00, 32'hE382A100, 32'hE382A300, 32'hE382A500, 32'hE382A700, 32'hE382A900,
        32'hE3838300, 32'hE383A300, 32'hE383A500, 32'hE383A700, 32'hE383AE00, 32'hE383B500,
        32'hE383B600, 32'hE3829B00, 32'hE3829C00, 32'hE383BD00, 32'hE383BE00, 32'hE3829D00,
        32'hE3829E00, 32'hE2809500, 32'hE2809000, 32'hC2B00000, 32'hE280B200, 32'hE280B300,
        32'hE2848300, 32'hEFBC8500, 32'hEFBDA100, 32'hEFBDA300, 32'hEFBDA400, 32'hEFBDB000,
        32'hEFBE9E00, 32'hEFBE9F00
    };

    // Characters that may not end a line.
    localparam int END_COUNT = 20;
    localparam logic [31:0] END_LIST [END_COUNT] = '{
        32'hE2809800, 32'hE2809C00, 32'hEFBC8800, 32'hE3809400, 32'hEFBCBB00, 32'hEFBD9B00,
        32'hE3808800, 32'hE3808A00, 32'hE3808C00, 32'hE3808E00, 32'hE3809000, 32'hEFBFA500,
        32'hEFBC8400, 32'hC2A20000, 32'hC2A30000, 32'hEFBCA000, 32'hC2A70000, 32'hE3809200,
        32'hEFBC8300, 32'hEFBDA200
    };

    // CJK ranges in which a multi-byte character may break.
    localparam int RANGE_COUNT = 6;
    localparam logic [31:0] RANGE_LO [RANGE_COUNT] = '{
        32'hE3808000, 32'hEFBC8000, 32'hE3818000, 32'hE382A000, 32'hE4B88000, 32'hEFA48000
    };
    localparam logic [31:0] RANGE_HI [RANGE_COUNT] = '{
        32'hE380BF00, 32'hEFBFAF00, 32'hE3829F00, 32'hE383BF00, 32'hE9BFBF00, 32'hEFABBF00
    };

    // Character length from its lead byte (1 to 4).
    function automatic logic [2:0] lead_length(input logic [7:0] lead);
        logic [1:0] code;
        code = LEAD_LENGTH_CODES[{lead[7:4], 1'b0} +: 2];
        return {1'b0, code} + 3'd1;
    endfunction

    // Separators after which a one-byte character may break.
    function automatic logic ascii_breaks(input logic [7:0] c);
        logic r;
        unique case (c) inside
            8'h00, 8'h09, 8'h0A, 8'h20, 8'h26, 8'h2A, 8'h2B, 8'h2D,
            8'h2F, 8'h3C, 8'h3D, 8'h3E, 8'h5C, 8'h5E, 8'h7C: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // Parallel match against the begin-taboo table.
    function automatic logic in_begin_list(input logic [31:0] word);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < BEGIN_COUNT; i++) begin
            hit = hit | (word == BEGIN_LIST[i]);
        end
        return hit;
    endfunction

    // Parallel match against the end-taboo table.
    function automatic logic in_end_list(input logic [31:0] word);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < END_COUNT; i++) begin
            hit = hit | (word == END_LIST[i]);
        end
        return hit;
    endfunction

    // Parallel range checks over the CJK blocks.
    function automatic logic in_cjk_range(input logic [31:0] word);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < RANGE_COUNT; i++) begin
            hit = hit | ((word >= RANGE_LO[i]) && (word <= RANGE_HI[i]));
        end
        return hit;
    endfunction

    // Gather the per-character properties.
    function automatic char_flags_t char_flags(input logic [31:0] word, input logic [2:0] len);
        char_flags_t f;
        f.len1      = (len == 3'd1);
        f.ascii_brk = ascii_breaks(word[31:24]);
        f.end_taboo = in_end_list(word);
        f.cjk_range = in_cjk_range(word);
        return f;
    endfunction

    // Break decision given what follows the character.
    function automatic logic decide(input char_flags_t f, input logic next_cut,
                                    input logic next_begin);
        logic r;
        if (f.len1) begin
            r = f.ascii_brk;
        end
        else if (f.end_taboo) begin
            r = 1'b0;
        end
        else if (next_cut) begin
            r = 1'b1;
        end
        else if (next_begin) begin
            r = 1'b0;
        end
        else begin
            r = f.cjk_range;
        end
        return r;
    endfunction

endpackage

@@ src/cjklb_core.sv @@
// Character assembly, one-character lookahead and break decision for each text byte.
`timescale 1ns / 1ps

module cjklb_core #(
    parameter int POSITION_BITS = cjklb_pkg::POSITION_BITS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        text_byte,
    input  logic              final_byte,
    output cjklb_pkg::push_t  push
);

    // Control state.
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [2:0]               have_reg, have_next;
    logic                     pend_valid_reg, pend_valid_next;

    // Payload state.
    logic [31:0]              word_reg, word_next;
    logic [2:0]               need_reg, need_next;
    logic [POSITION_BITS-1:0] astart_reg, astart_next;
    logic [2:0]               pend_len_reg, pend_len_next;
    logic [POSITION_BITS-1:0] pend_start_reg, pend_start_next;
    cjklb_pkg::char_flags_t   pend_flags_reg, pend_flags_next;

    // Values of the character after this byte is added.
    logic                     have_zero;
    logic                     stray;
    logic [31:0]              word_asm;
    logic [2:0]               need_asm;
    logic [2:0]               have_asm;
    logic [POSITION_BITS-1:0] start_asm;
    logic                     complete;
    logic                     cut;
    cjklb_pkg::char_flags_t   cur_flags;
    logic                     cur_begin;

    // Add the byte to the character under assembly.
    always_comb
    begin
        have_zero = (have_reg == 3'd0);
        stray     = have_zero && (text_byte[7:6] == 2'b10);
        if (have_zero) begin
            word_asm  = {text_byte, 24'h000000};
            need_asm  = cjklb_pkg::lead_length(text_byte);
            have_asm  = 3'd1;
            start_asm = pos_reg;
        end
        else begin
            case (have_reg[1:0])
                2'd1:    word_asm = word_reg | {8'h00, text_byte, 16'h0000};
                2'd2:    word_asm = word_reg | {16'h0000, text_byte, 8'h00};
                2'd3:    word_asm = word_reg | {24'h000000, text_byte};
                default: word_asm = word_reg | {text_byte, 24'h000000};
            endcase
            need_asm  = need_reg;
            have_asm  = have_reg + 3'd1;
            start_asm = astart_reg;
        end
        complete  = !stray && (have_asm >= need_asm);
        cut       = !stray && !complete && final_byte;
        cur_flags = cjklb_pkg::char_flags(word_asm, need_asm);
        cur_begin = cjklb_pkg::in_begin_list(word_asm);
    end

    // Results: the held-back character resolved by this byte, then the current character.
    always_comb
    begin
        push.a_valid            = step && pend_valid_reg && (stray || complete || cut);
        push.a.char_start       = cjklb_pkg::START_BITS'(32'(pend_start_reg));
        push.a.char_bytes       = pend_len_reg;
        push.a.break_allowed    = cjklb_pkg::decide(pend_flags_reg, cut, complete && cur_begin);
        push.a.cut_off          = 1'b0;
        push.a.end_of_text      = stray && final_byte;
        push.b_valid            = step && ((complete && final_byte) || cut);
        push.b.char_start       = cjklb_pkg::START_BITS'(32'(start_asm));
        push.b.char_bytes       = need_asm;
        push.b.break_allowed    = cut | cjklb_pkg::decide(cur_flags, 1'b0, 1'b0);
        push.b.cut_off          = cut;
        push.b.end_of_text      = 1'b1;
    end

    // Next state for one accepted byte.
    always_comb
    begin
        pos_next        = pos_reg;
        have_next       = have_reg;
        pend_valid_next = pend_valid_reg;
        word_next       = word_reg;
        need_next       = need_reg;
        astart_next     = astart_reg;
        pend_len_next   = pend_len_reg;
        pend_start_next = pend_start_reg;
        pend_flags_next = pend_flags_reg;
        if (step) begin
            if (final_byte) begin
                pos_next        = '0;
                have_next       = 3'd0;
                pend_valid_next = 1'b0;
            end
            else begin
                if (pos_reg != {POSITION_BITS{1'b1}}) begin
                    pos_next = pos_reg + POSITION_BITS'(1);
                end
                if (stray) begin
                    pend_valid_next = 1'b0;
                end
                else if (complete) begin
                    have_next       = 3'd0;
                    pend_valid_next = 1'b1;
                    pend_len_next   = need_asm;
                    pend_start_next = start_asm;
                    pend_flags_next = cur_flags;
                end
                else begin
                    have_next   = have_asm;
                    word_next   = word_asm;
                    need_next   = need_asm;
                    astart_next = start_asm;
                end
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg        <= '0;
            have_reg       <= 3'd0;
            pend_valid_reg <= 1'b0;
        end
        else begin
            pos_reg        <= pos_next;
            have_reg       <= have_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        word_reg       <= word_next;
        need_reg       <= need_next;
        astart_reg     <= astart_next;
        pend_len_reg   <= pend_len_next;
        pend_start_reg <= pend_start_next;
        pend_flags_reg <= pend_flags_next;
    end

    // A final byte leaves no character under assembly and nothing held back.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && final_byte |=> (have_reg == 3'd0) && !pend_valid_reg && (pos_reg == '0))
        else $error("state not cleared after final byte");

    // The current character is only reported at the end of the text.
    assert property (@(posedge clk) disable iff (!rst_n)
        push.b_valid |-> push.b.end_of_text && final_byte)
        else $error("current character reported before end of text");

    // A character under assembly never holds more bytes than its lead byte calls for.
    assert property (@(posedge clk) disable iff (!rst_n)
        (have_reg != 3'd0) |-> (have_reg < need_reg))
        else $error("assembly count overran character length");

endmodule

@@ src/cjklb_result_queue.sv @@
// Small result queue that takes up to two results per cycle and delivers one when the receiver does not stall.
`timescale 1ns / 1ps

module cjklb_result_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  cjklb_pkg::push_t    push,
    output logic                room,
    output logic                out_valid,
    input  logic                out_stall,
    output cjklb_pkg::result_t  head
);

    localparam int DEPTH = cjklb_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cjklb_pkg::result_t mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [1:0]         push_n;
    logic               pop;
    logic [PTR_W-1:0]   wr_second;

    // Head of the queue and free space for a full pair of results.
    assign out_valid = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign room      = (count_reg <= CNT_W'(DEPTH - 2));
    assign pop       = out_valid && !out_stall;
    assign push_n    = {1'b0, push.a_valid} + {1'b0, push.b_valid};
    assign wr_second = wr_ptr_reg + PTR_W'(1);

    // Pointer and count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push_n) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage: the held-back result goes in first, the current one after it.
    always_ff @(posedge clk)
    begin
        if (push.a_valid) begin
            mem_reg[wr_ptr_reg] <= push.a;
            if (push.b_valid) begin
                mem_reg[wr_second] <= push.b;
            end
        end
        else if (push.b_valid) begin
            mem_reg[wr_ptr_reg] <= push.b;
        end
    end

    // The queue never holds more than its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("result queue count out of range");

    // Results are only pushed when there is space for them.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push_n != 2'd0) |-> ((count_reg + CNT_W'(push_n)) <= CNT_W'(DEPTH)))
        else $error("result queue overflow");

endmodule

@@ src/utf8_cjk_line_break_classifier.sv @@
// Top level of the UTF-8 CJK line-break classifier.
`timescale 1ns / 1ps

// Usage:
// The input channel (in_valid, in_stall) carries one byte of UTF-8 text per
// transaction, with final_byte set on the last byte of a text. The output
// channel (out_valid, out_stall) carries one result per character: its start
// position, its length, whether a line may end after it, and the cut-off and
// end-of-text marks. Each decision waits for the following character, so a
// character's result leaves with the byte that completes the next character,
// with a stray continuation byte, or with the final byte of the text.
// A result passes through the input register, then the result queue, before it
// is presented; it can be taken at a clock edge when out_stall is low.
// Throughput: one byte per cycle while the result queue has room. One byte
// can produce two results; a four-entry result queue absorbs them, and the
// input stalls while that queue holds more than two results.
// When the receiver stalls, the head result holds steady and the queue fills;
// the input then stalls. Reset clears the position counter, the character
// under assembly and the held-back character; the next byte starts a new text
// at position zero, as it also does after any final byte.
module utf8_cjk_line_break_classifier #(
    parameter int POSITION_BITS = cjklb_pkg::POSITION_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  text_byte,
    input  logic        final_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] char_start,
    output logic [2:0]  char_bytes,
    output logic        break_allowed,
    output logic        cut_off,
    output logic        end_of_text
);

    logic               in_valid_reg, in_valid_next;
    logic [7:0]         byte_reg;
    logic               final_reg;
    logic               room;
    logic               advance;
    logic               accept;
    cjklb_pkg::push_t   push;
    cjklb_pkg::result_t head;

    // Input register handshake.
    assign advance  = in_valid_reg && room;
    assign in_stall = in_valid_reg && !room;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept) begin
            in_valid_next = 1'b1;
        end
        else if (advance) begin
            in_valid_next = 1'b0;
        end
        else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end
        else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            byte_reg  <= text_byte;
            final_reg <= final_byte;
        end
    end

    // Character assembly and break decisions.
    cjklb_core #(
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .text_byte  (byte_reg),
        .final_byte (final_reg),
        .push       (push)
    );

    // Result queue feeding the output channel.
    cjklb_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign char_start    = head.char_start;
    assign char_bytes    = head.char_bytes;
    assign break_allowed = head.break_allowed;
    assign cut_off       = head.cut_off;
    assign end_of_text   = head.end_of_text;

endmodule

@@ test/tb_top.sv @@
// Testbench for the UTF-8 CJK line-break classifier: directed, random and backpressure tests.
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int          DRAIN_CYCLES = 12;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          MAX_REPORTS  = 40;

    // Characters that may not begin a line.
    localparam logic [31:0] NO_LINE_START [62] = '{
        32'hE3808100, 32'hE3808200, 32'hEFBC8C00, 32'hEFBC8E00, 32'hEFBC9A00, 32'hEFBC9B00,
        32'hEFBC9F00, 32'hEFBC8100, 32'hE2809900, 32'hE2809D00, 32'hEFBC8900, 32'hE3809500,
        32'hEFBCBD00, 32'hEFBD9D00, 32'hE3808900, 32'hE3808B00, 32'hE3808D00, 32'hE3808F00,
        32'hE3809100, 32'hE3808500, 32'hE383BC00, 32'hE3818100, 32'hE3818300, 32'hE3818500,
        32'hE3818700, 32'hE3818900, 32'hE381A300, 32'hE3828300, 32'hE3828500, 32'hE3828700,
        32'hE3828E00, 32'hE382A100, 32'hE382A300, 32'hE382A500, 32'hE382A700, 32'hE382A900,
        32'hE3838300, 32'hE383A300, 32'hE383A500, 32'hE383A700, 32'hE383AE00, 32'hE383B500,
        32'hE383B600, 32'hE3829B00, 32'hE3829C00, 32'hE383BD00, 32'hE383BE00, 32'hE3829D00,
        32'hE3829E00, 32'hE2809500, 32'hE2809000, 32'hC2B00000, 32'hE280B200, 32'hE280B300,
        32'hE2848300, 32'hEFBC8500, 32'hEFBDA100, 32'hEFBDA300, 32'hEFBDA400, 32'hEFBDB000,
        32'hEFBE9E00, 32'hEFBE9F00
    };

    // Characters that may not end a line.
    localparam logic [31:0] NO_LINE_END [20] = '{
        32'hE2809800, 32'hE2809C00, 32'hEFBC8800, 32'hE3809400, 32'hEFBCBB00, 32'hEFBD9B00,
        32'hE3808800, 32'hE3808A00, 32'hE3808C00, 32'hE3808E00, 32'hE3809000, 32'hEFBFA500,
        32'hEFBC8400, 32'hC2A20000, 32'hC2A30000, 32'hEFBCA000, 32'hC2A70000, 32'hE3809200,
        32'hEFBC8300, 32'hEFBDA200
    };

    // CJK blocks whose characters may break.
    localparam logic [31:0] BREAK_RANGE_LO [6] = '{
        32'hE3808000, 32'hEFBC8000, 32'hE3818000, 32'hE382A000, 32'hE4B88000, 32'hEFA48000
    };
    localparam logic [31:0] BREAK_RANGE_HI [6] = '{
        32'hE380BF00, 32'hEFBFAF00, 32'hE3829F00, 32'hE383BF00, 32'hE9BFBF00, 32'hEFABBF00
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  text_byte = 8'h00;
    logic        final_byte = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] char_start;
    logic [2:0]  char_bytes;
    logic        break_allowed;
    logic        cut_off;
    logic        end_of_text;

    // Model state: position counter, character under assembly, held-back character.
    logic [15:0] pos_cnt = '0;
    logic [31:0] asm_word = '0;
    logic [2:0]  asm_need = '0;
    logic [2:0]  asm_have = '0;
    logic [15:0] asm_start = '0;
    logic        held_valid = 1'b0;
    logic [31:0] held_word = '0;
    logic [2:0]  held_len = '0;
    logic [15:0] held_start = '0;

    cjklb_pkg::result_t expected_chars [$];
    cjklb_pkg::result_t want;
    logic [7:0]  text_bytes [$];
    int          errors = 0;
    int          bytes_sent = 0;
    int unsigned cycle_count = 0;
    bit          idling = 1'b1;
    int          hold_request = 0;

    utf8_cjk_line_break_classifier dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .text_byte     (text_byte),
        .final_byte    (final_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .char_start    (char_start),
        .char_bytes    (char_bytes),
        .break_allowed (break_allowed),
        .cut_off       (cut_off),
        .end_of_text   (end_of_text)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Character length from the lead byte.
    function automatic logic [2:0] char_len_of(input logic [7:0] lead);
        if (lead >= 8'hF0)
            return 3'd4;
        else if (lead >= 8'hE0)
            return 3'd3;
        else if (lead >= 8'hC0)
            return 3'd2;
        return 3'd1;
    endfunction

    // Break decision for one character given what follows it.
    function automatic logic may_break(input logic [31:0] word, input logic [2:0] len,
                                       input logic has_next, input logic next_cut,
                                       input logic [31:0] next_word);
        logic r;
        r = 1'b0;
        if (len == 3'd1)
        begin
            case (word[31:24]) inside
                8'h00, 8'h09, 8'h0A, 8'h20, 8'h26, 8'h2A, 8'h2B, 8'h2D,
                8'h2F, 8'h3C, 8'h3D, 8'h3E, 8'h5C, 8'h5E, 8'h7C: r = 1'b1;
                default: r = 1'b0;
            endcase
            return r;
        end
        for (int i = 0; i < 20; i++)
        begin
            if (word == NO_LINE_END[i])
                return 1'b0;
        end
        if (has_next)
        begin
            if (next_cut)
                return 1'b1;
            for (int i = 0; i < 62; i++)
            begin
                if (next_word == NO_LINE_START[i])
                    return 1'b0;
            end
        end
        for (int i = 0; i < 6; i++)
        begin
            if (word >= BREAK_RANGE_LO[i] && word <= BREAK_RANGE_HI[i])
                r = 1'b1;
        end
        return r;
    endfunction

    function automatic void queue_result(input logic [15:0] start, input logic [2:0] len,
                                         input logic brk, input logic cut, input logic eot);
        cjklb_pkg::result_t r;
        r.char_start    = start;
        r.char_bytes    = len;
        r.break_allowed = brk;
        r.cut_off       = cut;
        r.end_of_text   = eot;
        expected_chars.push_back(r);
    endfunction

    // Advance the model by one accepted byte and queue the results it causes.
    task automatic predict_byte(input logic [7:0] b, input logic fin);
        logic done;
        logic cut;
        int   sh;
        done = 1'b0;
        cut  = 1'b0;
        if (asm_have == 3'd0)
        begin
            if (b[7:6] == 2'b10)
            begin
                // A stray continuation byte resolves the held character but is not one itself.
                if (held_valid)
                begin
                    queue_result(held_start, held_len,
                                 may_break(held_word, held_len, 1'b1, 1'b0, {b, 24'h0}),
                                 1'b0, fin);
                    held_valid = 1'b0;
                end
            end
            else
            begin
                asm_word  = {b, 24'h0};
                asm_need  = char_len_of(b);
                asm_have  = 3'd1;
                asm_start = pos_cnt;
                if (asm_need == 3'd1)
                    done = 1'b1;
                else if (fin)
                    cut = 1'b1;
            end
        end
        else
        begin
            sh = 24 - 8 * int'(asm_have[1:0]);
            asm_word = asm_word | ({24'h0, b} << sh);
            asm_have = {1'b0, asm_have[1:0]} + 3'd1;
            if (asm_have >= asm_need)
                done = 1'b1;
            else if (fin)
                cut = 1'b1;
        end

        if (done)
        begin
            if (held_valid)
                queue_result(held_start, held_len,
                             may_break(held_word, held_len, 1'b1, 1'b0, asm_word), 1'b0, 1'b0);
            if (fin)
            begin
                queue_result(asm_start, asm_need,
                             may_break(asm_word, asm_need, 1'b0, 1'b0, 32'h0), 1'b0, 1'b1);
                held_valid = 1'b0;
            end
            else
            begin
                held_valid = 1'b1;
                held_word  = asm_word;
                held_len   = asm_need;
                held_start = asm_start;
            end
            asm_have = 3'd0;
            asm_word = 32'h0;
            asm_need = 3'd0;
        end
        else if (cut)
        begin
            if (held_valid)
                queue_result(held_start, held_len,
                             may_break(held_word, held_len, 1'b1, 1'b1, 32'h0), 1'b0, 1'b0);
            queue_result(asm_start, asm_need, 1'b1, 1'b1, 1'b1);
        end

        // A final byte returns everything to the reset state.
        if (fin)
        begin
            pos_cnt    = '0;
            asm_word   = '0;
            asm_need   = '0;
            asm_have   = '0;
            asm_start  = '0;
            held_valid = 1'b0;
            held_word  = '0;
            held_len   = '0;
            held_start = '0;
        end
        else if (pos_cnt != 16'hFFFF)
            pos_cnt = pos_cnt + 16'd1;
    endtask

    // Offer one byte and wait for the transaction to be accepted.
    task automatic send_byte(input logic [7:0] b, input logic fin, input bit allow_gaps);
        if (idling && allow_gaps && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        text_byte  <= b;
        final_byte <= fin;
        do
            @(posedge clk);
        while (in_stall);
        predict_byte(b, fin);
        bytes_sent++;
    endtask

    task automatic send_text(input bit allow_gaps);
        for (int i = 0; i < text_bytes.size(); i++)
            send_byte(text_bytes[i], i == text_bytes.size() - 1, allow_gaps);
    endtask

    task automatic append_word(input logic [31:0] w);
        int n;
        n = char_len_of(w[31:24]);
        for (int i = 0; i < n; i++)
            text_bytes.push_back(w[31 - 8 * i -: 8]);
    endtask

    // One random character, weighted toward the taboo lists and the CJK block edges.
    task automatic append_char();
        int          kind;
        logic [31:0] w;
        logic [7:0]  lead;
        kind = $urandom_range(0, 99);
        if (kind < 35)
            text_bytes.push_back(8'($urandom_range(0, 127)));
        else if (kind < 43)
            text_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
        else if (kind < 58)
            append_word(NO_LINE_START[$urandom_range(0, 61)]);
        else if (kind < 68)
            append_word(NO_LINE_END[$urandom_range(0, 19)]);
        else if (kind < 78)
        begin
            w = $urandom_range(0, 1) ? BREAK_RANGE_HI[$urandom_range(0, 5)]
                                     : BREAK_RANGE_LO[$urandom_range(0, 5)];
            case ($urandom_range(0, 2))
                0: w = w - 32'h100;
                1: w = w + 32'h100;
                default: w = w;
            endcase
            append_word(w);
        end
        else if (kind < 90)
            append_word({8'hE3, 8'($urandom_range(8'h80, 8'h83)),
                         8'($urandom_range(8'h80, 8'hBF)), 8'h00});
        else
        begin
            // Any lead byte, with trailing bytes of any value.
            lead = 8'($urandom_range(8'hC0, 8'hFF));
            text_bytes.push_back(lead);
            repeat (char_len_of(lead) - 1)
                text_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // A random text: mostly well-formed characters, sometimes cut off, sometimes raw noise.
    task automatic build_text();
        logic [7:0] lead;
        text_bytes.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 10))
                text_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            repeat ($urandom_range(1, 10))
                append_char();
            if ($urandom_range(0, 4) == 0)
            begin
                lead = 8'($urandom_range(8'hC0, 8'hFF));
                text_bytes.push_back(lead);
                repeat ($urandom_range(0, char_len_of(lead) - 2))
                    text_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (want_v !== got_v)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t ns: %s mismatch: expected %0d, actual %0d",
                         $time, name, want_v, got_v);
        end
    endtask

    // Compare every accepted result transaction with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_chars.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t ns: unexpected result: expected none, actual start %0d len %0d",
                             $time, char_start, char_bytes);
            end
            else
            begin
                want = expected_chars.pop_front();
                check_field("char_start", want.char_start, char_start);
                check_field("char_bytes", 16'(want.char_bytes), 16'(char_bytes));
                check_field("break_allowed", 16'(want.break_allowed), 16'(break_allowed));
                check_field("cut_off", 16'(want.cut_off), 16'(cut_off));
                check_field("end_of_text", 16'(want.end_of_text), 16'(end_of_text));
            end
        end
    end

    // Receiver: random stall bursts, quiet stretches, and a long hold-off on request.
    initial
    begin : receiver_stall
        int n;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                n = hold_request;
                hold_request = 0;
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (idling && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (idling && $urandom_range(0, 15) == 0)
            begin
                repeat ($urandom_range(20, 60)) @(posedge clk);
            end
        end
    end

    // Separators and other one-byte characters, ending on a complete final character.
    task automatic test_ascii_separators();
        text_bytes = '{8'h00, 8'h41, 8'h2F, 8'h7F, 8'h20};
        send_text(1'b1);
    endtask

    // Begin and end taboo characters, a stray byte, and a cut-off character at the end.
    task automatic test_cjk_taboo();
        text_bytes = '{8'hE4, 8'hB8, 8'h80, 8'hE3, 8'h80, 8'h81, 8'h80, 8'hC2, 8'hA2,
                       8'hE3, 8'h80, 8'h8C, 8'hF0, 8'h9F, 8'h98};
        send_text(1'b1);
    endtask

    // A final stray byte with nothing held, and the highest lead byte as a four-byte lead.
    task automatic test_odd_leads();
        text_bytes = '{8'hBF};
        send_text(1'b1);
        text_bytes = '{8'hFF, 8'h01, 8'h02, 8'h03};
        send_text(1'b1);
    endtask

    task automatic test_random_text(input int byte_goal);
        while (bytes_sent < byte_goal)
        begin
            build_text();
            send_text($urandom_range(0, 3) != 0);
        end
    endtask

    // The receiver holds off while the sender keeps offering, so the result queue fills.
    task automatic test_backpressure();
        hold_request = HOLD_CYCLES;
        repeat (4)
        begin
            build_text();
            send_text(1'b0);
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_ascii_separators();
        test_cjk_taboo();
        test_odd_leads();
        test_random_text(850);
        test_backpressure();

        // Last part of the run: no idling on either side.
        idling = 1'b0;
        test_random_text(1100);
        in_valid <= 1'b0;

        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
